// ===== rtl/lao_pkg.sv =====
// Shared types, constants and helper functions for the toroidal life automaton.
// Used by the channel interfaces, the row cell, the rule unit and the top level.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lao_pkg;

  localparam int ROWS  = 32;
  localparam int COLS  = 64;
  localparam int ROW_W = 5;   // row index width
  localparam int RCNT_W = 6;  // row count width (holds ROWS itself)
  localparam int CCNT_W = 7;  // column count width (holds COLS itself)
  localparam int CIDX_W = 6;  // column index width
  localparam int CFG_W  = 7;  // widest configuration register

  localparam logic [RCNT_W-1:0] ROWS_RESET = 6'd25;
  localparam logic [CCNT_W-1:0] COLS_RESET = 7'd64;
  localparam logic [RCNT_W-1:0] ROWS_MIN   = 6'd3;
  localparam logic [RCNT_W-1:0] ROWS_MAX   = RCNT_W'(ROWS);
  localparam logic [CCNT_W-1:0] COLS_MIN   = 7'd3;
  localparam logic [CCNT_W-1:0] COLS_MAX   = CCNT_W'(COLS);

  // Life rule: a live cell survives on two or three neighbors, a dead cell is born on three.
  localparam logic [3:0] SURVIVE_LOW = 4'd2;
  localparam logic [3:0] BIRTH_COUNT = 4'd3;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } lao_op_t;

  typedef enum logic {
    CFG_ROWS_IN_USE = 1'b0,
    CFG_COLS_IN_USE = 1'b1
  } lao_cfg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } lao_state_t;

  typedef struct packed {
    logic shift;  // take the neighbor's row or the rule unit's result
    logic tail;   // this cell is the last active row of the chain
    logic load;   // write the loaded row
  } lao_cell_ctrl_t;

  function automatic logic [RCNT_W-1:0] clamp_rows(input logic [RCNT_W-1:0] r);
    logic [RCNT_W-1:0] v;
    v = r;
    if (r < ROWS_MIN) v = ROWS_MIN;
    if (r > ROWS_MAX) v = ROWS_MAX;
    return v;
  endfunction

  function automatic logic [CCNT_W-1:0] clamp_cols(input logic [CCNT_W-1:0] c);
    logic [CCNT_W-1:0] v;
    v = c;
    if (c < COLS_MIN) v = COLS_MIN;
    if (c > COLS_MAX) v = COLS_MAX;
    return v;
  endfunction

  function automatic logic [COLS-1:0] col_mask(input logic [CCNT_W-1:0] c);
    logic [COLS-1:0] m;
    for (int j = 0; j < COLS; j++) begin
      m[j] = (CCNT_W'(j) < c);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lao_if.sv =====
// Valid/ready channel interfaces for the life automaton: load/step items in, rows out.
// Depends on lao_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lao_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [lao_pkg::ROW_W-1:0]  row_index;
  logic [lao_pkg::COLS-1:0]   row_bits;

  modport source (output valid, opcode, row_index, row_bits, input ready);
  modport sink   (input valid, opcode, row_index, row_bits, output ready);
endinterface

interface lao_out_if;
  logic                       valid;
  logic                       ready;
  logic [lao_pkg::ROW_W-1:0]  out_row;
  logic [lao_pkg::COLS-1:0]   out_cells;
  logic                       row_changed;
  logic                       grid_stable;
  logic                       last;

  modport source (output valid, out_row, out_cells, row_changed, grid_stable, last,
                  input ready);
  modport sink   (input valid, out_row, out_cells, row_changed, grid_stable, last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/lao_row_cell.sv =====
// One row of the grid, held as a link of the row chain.
// Depends on lao_pkg for the control struct and the row width.
`timescale 1ns / 1ps
`default_nettype none

module lao_row_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire lao_pkg::lao_cell_ctrl_t ctrl,
  input  wire  [lao_pkg::COLS-1:0]     from_next,
  input  wire  [lao_pkg::COLS-1:0]     from_unit,
  input  wire  [lao_pkg::COLS-1:0]     load_bits,
  output logic [lao_pkg::COLS-1:0]     row_q
);

  logic [lao_pkg::COLS-1:0] row_r;
  logic [lao_pkg::COLS-1:0] row_nxt;

  // During a step the rows move one place toward the head each cycle that the shift control
  // is set, and the last active cell takes the freshly computed row.
  always_comb begin
    row_nxt = row_r;
    if (ctrl.load) begin
      row_nxt = load_bits;
    end else if (ctrl.shift) begin
      row_nxt = ctrl.tail ? from_unit : from_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_q = row_r;

endmodule

`default_nettype wire

// ===== rtl/lao_rule_unit.sv =====
// Next-generation rule for one row: 64 column lanes with wraparound at the column count.
// Depends on lao_pkg for widths and the rule constants.
`timescale 1ns / 1ps
`default_nettype none

module lao_rule_unit (
  input  wire  [lao_pkg::COLS-1:0]    above,
  input  wire  [lao_pkg::COLS-1:0]    cur,
  input  wire  [lao_pkg::COLS-1:0]    below,
  input  wire  [lao_pkg::CCNT_W-1:0]  cols,
  output logic [lao_pkg::COLS-1:0]    nxt
);

  logic [lao_pkg::CIDX_W-1:0] col_last;

  assign col_last = lao_pkg::CIDX_W'(cols - lao_pkg::CCNT_W'(1));

  for (genvar j = 0; j < lao_pkg::COLS; j++) begin : g_lane
    logic [lao_pkg::CIDX_W-1:0] li;
    logic [lao_pkg::CIDX_W-1:0] ri;
    logic [3:0]                 n;

    // Left neighbor of column zero and right neighbor of the last column wrap around.
    assign li = (j == 0) ? col_last : lao_pkg::CIDX_W'(j - 1);
    assign ri = (lao_pkg::CCNT_W'(j + 1) == cols) ? '0 : lao_pkg::CIDX_W'(j + 1);

    assign n = 4'(above[li]) + 4'(above[j]) + 4'(above[ri])
             + 4'(cur[li])                  + 4'(cur[ri])
             + 4'(below[li]) + 4'(below[j]) + 4'(below[ri]);

    assign nxt[j] = (lao_pkg::CCNT_W'(j) < cols) &&
                    (cur[j] ? (n == lao_pkg::SURVIVE_LOW || n == lao_pkg::BIRTH_COUNT)
                            : (n == lao_pkg::BIRTH_COUNT));
  end

endmodule

`default_nettype wire

// ===== rtl/life_automaton_generation_step.sv =====
// Life automaton on a torus of up to 32 rows by 64 columns. A load item writes one row and
// returns nothing. A step item first latches the wrap rows, then handles the active rows
// one after another: the rows travel along a chain of row registers toward the head, where
// a single rule unit computes the next generation of the head row and hands it to the tail
// of the chain, and the step holds whenever the output is stalled. Rows come out in order
// 0 upward with a changed flag; the last one carries the stable flag.
// Depends on lao_pkg, lao_if, lao_row_cell and lao_rule_unit.
`timescale 1ns / 1ps
`default_nettype none

module life_automaton_generation_step (
  input  wire                              clk,
  input  wire                              rst_n,
  lao_in_if.sink                           in_ch,
  lao_out_if.source                        out_ch,
  input  wire                              cfg_we,
  input  wire                              cfg_index,
  input  wire  [lao_pkg::CFG_W-1:0]        cfg_wdata
);

  logic [lao_pkg::RCNT_W-1:0] rows_cfg_r;
  logic [lao_pkg::CCNT_W-1:0] cols_cfg_r;
  logic [lao_pkg::RCNT_W-1:0] rows_act;
  logic [lao_pkg::ROW_W-1:0]  rows_m1;
  logic [lao_pkg::CCNT_W-1:0] cols_act;
  logic [lao_pkg::COLS-1:0]   col_m;

  lao_pkg::lao_state_t        state_r;
  lao_pkg::lao_state_t        state_nxt;
  logic                       in_ready;
  logic                       unit_fire;
  logic                       in_fire;
  logic                       step_start;
  logic                       load_fire;

  logic [lao_pkg::ROW_W-1:0]  row_cnt_r;
  logic                       row_last;
  logic [lao_pkg::COLS-1:0]   first_r;
  logic [lao_pkg::COLS-1:0]   above_r;
  logic                       any_change_r;

  logic [lao_pkg::COLS-1:0]   cell_q [lao_pkg::ROWS];
  logic [lao_pkg::COLS-1:0]   cur;
  logic [lao_pkg::COLS-1:0]   below;
  logic [lao_pkg::COLS-1:0]   nxt;
  logic [lao_pkg::COLS-1:0]   load_bits;
  logic                       changed;

  logic                       out_valid_r;
  logic [lao_pkg::ROW_W-1:0]  out_row_r;
  logic [lao_pkg::COLS-1:0]   out_cells_r;
  logic                       row_changed_r;
  logic                       grid_stable_r;
  logic                       last_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= lao_pkg::ROWS_RESET;
      cols_cfg_r <= lao_pkg::COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lao_pkg::CFG_ROWS_IN_USE: rows_cfg_r <= cfg_wdata[lao_pkg::RCNT_W-1:0];
        lao_pkg::CFG_COLS_IN_USE: cols_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign rows_act = lao_pkg::clamp_rows(rows_cfg_r);
  assign rows_m1  = lao_pkg::ROW_W'(rows_act - lao_pkg::RCNT_W'(1));
  assign cols_act = lao_pkg::clamp_cols(cols_cfg_r);
  assign col_m    = lao_pkg::col_mask(cols_act);

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign step_start = in_fire && (in_ch.opcode == lao_pkg::OP_STEP);
  assign load_fire  = in_fire && (in_ch.opcode == lao_pkg::OP_LOAD);
  assign row_last   = (row_cnt_r == rows_m1);

  // Control: idle takes items; run emits one row each cycle the output register is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lao_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    unit_fire = 1'b0;
    case (state_r)
      lao_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (step_start) state_nxt = lao_pkg::ST_RUN;
      end
      lao_pkg::ST_RUN: begin
        unit_fire = !out_valid_r || out_ch.ready;
        if (unit_fire && row_last) state_nxt = lao_pkg::ST_IDLE;
      end
      default: state_nxt = lao_pkg::ST_IDLE;
    endcase
  end

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r    <= '0;
      any_change_r <= 1'b0;
    end else if (step_start) begin
      row_cnt_r    <= '0;
      any_change_r <= 1'b0;
    end else if (unit_fire) begin
      row_cnt_r    <= row_cnt_r + lao_pkg::ROW_W'(1);
      any_change_r <= any_change_r || changed;
    end
  end

  // Old row zero is kept for the bottom wrap; the row above starts as the last active row.
  always_ff @(posedge clk) begin
    if (step_start) begin
      first_r <= cell_q[0] & col_m;
      above_r <= cell_q[rows_m1] & col_m;
    end else if (unit_fire) begin
      above_r <= cur;
    end
  end

  assign cur       = cell_q[0] & col_m;
  assign below     = row_last ? first_r : (cell_q[1] & col_m);
  assign changed   = (nxt != cur);
  assign load_bits = in_ch.row_bits & col_m;

  lao_rule_unit u_rule (
    .above (above_r),
    .cur   (cur),
    .below (below),
    .cols  (cols_act),
    .nxt   (nxt)
  );

  for (genvar k = 0; k < lao_pkg::ROWS; k++) begin : g_cell
    lao_pkg::lao_cell_ctrl_t  ctrl;
    logic [lao_pkg::COLS-1:0] from_next;

    assign ctrl.shift = unit_fire && (lao_pkg::ROW_W'(k) <= rows_m1);
    assign ctrl.tail  = (lao_pkg::ROW_W'(k) == rows_m1);
    assign ctrl.load  = load_fire && (in_ch.row_index == lao_pkg::ROW_W'(k));

    if (k == lao_pkg::ROWS - 1) begin : g_end
      assign from_next = nxt;
    end else begin : g_mid
      assign from_next = cell_q[k+1];
    end

    lao_row_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .from_next (from_next),
      .from_unit (nxt),
      .load_bits (load_bits),
      .row_q     (cell_q[k])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (unit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (unit_fire) begin
      out_row_r     <= row_cnt_r;
      out_cells_r   <= nxt;
      row_changed_r <= changed;
      grid_stable_r <= row_last && !(any_change_r || changed);
      last_r        <= row_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_row     = out_row_r;
  assign out_ch.out_cells   = out_cells_r;
  assign out_ch.row_changed = row_changed_r;
  assign out_ch.grid_stable = grid_stable_r;
  assign out_ch.last        = last_r;

  a_last_ends_step: assert property (@(posedge clk) disable iff (!rst_n)
    (unit_fire && row_last) |=> (state_r == lao_pkg::ST_IDLE))
    else $error("step did not end after its last row");

  a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (unit_fire && !row_last) |=>
      (state_r == lao_pkg::ST_RUN && row_cnt_r == $past(row_cnt_r) + lao_pkg::ROW_W'(1)))
    else $error("row counter did not advance by one");

  a_stable_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && grid_stable_r) |-> (last_r && !row_changed_r))
    else $error("stable flag on a row that is not a quiet last row");

  a_no_item_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lao_pkg::ST_RUN) |-> !in_fire)
    else $error("item accepted during a step");

endmodule

`default_nettype wire
